/* rtl/pbfa_pkg.sv */
// shared constants, types and helper functions of the packed bit field array
package pbfa_pkg;

    localparam int WORD_COUNT  = 1024;
    localparam int WORD_BITS   = 64;
    localparam int OFFSET_W    = $clog2(WORD_BITS);
    localparam int SHIFT_W     = OFFSET_W + 1;
    localparam int PAIR_BITS   = 2 * WORD_BITS;

    // even words in one bank, odd words in the other
    localparam int ROW_DEPTH   = (WORD_COUNT + 1) / 2;
    localparam int ROW_W       = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;

    localparam int POS_W       = 16;
    localparam int WIDTH_W     = 7;
    localparam int COUNT_W     = 17;
    localparam int START_W     = POS_W + WIDTH_W;
    localparam int WIDX_W      = START_W - OFFSET_W;

    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 17;

    localparam logic [CFG_INDEX_W-1:0] CFG_BITS_PER_ELEMENT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ELEMENT_COUNT    = 1'b1;

    localparam logic [WIDTH_W-1:0] BITS_PER_ELEMENT_RST = 7'd8;
    localparam logic [COUNT_W-1:0] ELEMENT_COUNT_RST    = 17'd8192;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MODIFY
    } pbfa_state_t;

    typedef struct packed {
        logic clear;
        logic load;
        logic lookup;
        logic commit;
    } pbfa_cmd_t;

    typedef struct packed {
        logic clear_last;
    } pbfa_status_t;

    // n low ones, n in 1..64
    function automatic logic [WORD_BITS-1:0] low_ones(input logic [WIDTH_W-1:0] n);
        logic [WORD_BITS-1:0] r;
        if (n >= WIDTH_W'(WORD_BITS))
            r = '1;
        else
            r = (WORD_BITS'(1) << n) - WORD_BITS'(1);
        return r;
    endfunction

    // zero reads as one, anything above 64 as 64
    function automatic logic [WIDTH_W-1:0] eff_width(input logic [WIDTH_W-1:0] cfg);
        logic [WIDTH_W-1:0] r;
        if (cfg == '0)
            r = WIDTH_W'(1);
        else if (cfg > WIDTH_W'(WORD_BITS))
            r = WIDTH_W'(WORD_BITS);
        else
            r = cfg;
        return r;
    endfunction

endpackage

/* rtl/pbfa_if.sv */
// request and response channel interfaces of the packed bit field array
interface pbfa_req_if;
    import pbfa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 action;
    logic [POS_W-1:0]     position;
    logic [WORD_BITS-1:0] write_value;

    modport source (output valid, action, position, write_value, input ready);
    modport sink   (input valid, action, position, write_value, output ready);
endinterface

interface pbfa_rsp_if;
    import pbfa_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [WORD_BITS-1:0] read_value;
    logic                 out_of_range;

    modport source (output valid, read_value, out_of_range, input ready);
    modport sink   (input valid, read_value, out_of_range, output ready);
endinterface

/* rtl/pbfa_ram.sv */
// generic simple dual port ram with registered read
module pbfa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/pbfa_ctrl.sv */
// sequencer: clearing pass, request intake, lookup and commit steps, response valid
module pbfa_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  req_valid,
    output logic                  req_ready,
    output logic                  rsp_valid,
    input  logic                  rsp_ready,
    input  pbfa_pkg::pbfa_status_t status,
    output pbfa_pkg::pbfa_cmd_t    cmd
);
    import pbfa_pkg::*;

    pbfa_state_t state_reg, state_next;
    logic        rsp_valid_reg, rsp_valid_next;
    logic        out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign out_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (status.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.lookup = 1'b1;
                state_next = ST_MODIFY;
            end
            ST_MODIFY:
            begin
                if (out_free)
                begin
                    cmd.commit = 1'b1;
                    req_ready  = 1'b1;
                    if (req_valid)
                    begin
                        cmd.load   = 1'b1;
                        state_next = ST_READ;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.commit)
            rsp_valid_next = 1'b1;
        else if (rsp_ready)
            rsp_valid_next = 1'b0;
        else
            rsp_valid_next = rsp_valid_reg;
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

/* rtl/pbfa_dp.sv */
// datapath: config registers, address math, banked word store, extract and merge
module pbfa_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pbfa_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [pbfa_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  pbfa_pkg::pbfa_cmd_t               cmd,
    output pbfa_pkg::pbfa_status_t            status,
    input  logic                              req_action,
    input  logic [pbfa_pkg::POS_W-1:0]        req_position,
    input  logic [pbfa_pkg::WORD_BITS-1:0]    req_write_value,
    output logic [pbfa_pkg::WORD_BITS-1:0]    rsp_read_value,
    output logic                              rsp_out_of_range
);
    import pbfa_pkg::*;

    // configuration
    logic [WIDTH_W-1:0]   bpe_reg;
    logic [COUNT_W-1:0]   count_reg;

    // clearing pass
    logic [ROW_W-1:0]     clr_row_reg;

    // load step
    logic                 act_reg;
    logic [WIDTH_W-1:0]   width_reg;
    logic [WORD_BITS-1:0] value_reg;
    logic [START_W-1:0]   start_reg;
    logic                 pos_bad_reg;
    logic [WIDTH_W-1:0]   width_next;

    // lookup step
    logic [START_W-1:0]   last_bit;
    logic [WIDX_W-1:0]    w0;
    logic [WIDX_W-1:0]    w1;
    logic [ROW_W-1:0]     row0;
    logic [ROW_W-1:0]     even_row;
    logic [SHIFT_W:0]     shift_wide;
    logic                 bad_next;
    logic                 straddle_reg;
    logic                 bad_reg;
    logic                 swap_reg;
    logic [SHIFT_W-1:0]   shift_reg;
    logic [ROW_W-1:0]     even_row_reg;
    logic [ROW_W-1:0]     odd_row_reg;

    // commit step
    logic [WORD_BITS-1:0] even_rdata;
    logic [WORD_BITS-1:0] odd_rdata;
    logic [PAIR_BITS-1:0] pair;
    logic [PAIR_BITS-1:0] field_mask;
    logic [PAIR_BITS-1:0] field_ins;
    logic [PAIR_BITS-1:0] new_pair;
    logic [WORD_BITS-1:0] extracted;
    logic                 do_write;
    logic                 even_we;
    logic                 odd_we;
    logic [ROW_W-1:0]     even_waddr;
    logic [ROW_W-1:0]     odd_waddr;
    logic [WORD_BITS-1:0] even_wdata;
    logic [WORD_BITS-1:0] odd_wdata;
    logic [WORD_BITS-1:0] read_value_reg;
    logic                 oor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpe_reg     <= BITS_PER_ELEMENT_RST;
            count_reg   <= ELEMENT_COUNT_RST;
            clr_row_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_BITS_PER_ELEMENT: bpe_reg   <= cfg_data[WIDTH_W-1:0];
                    CFG_ELEMENT_COUNT:    count_reg <= cfg_data[COUNT_W-1:0];
                    default:              ;
                endcase
            end
            if (cmd.clear)
                clr_row_reg <= clr_row_reg + ROW_W'(1);
        end
    end

    assign status.clear_last = (clr_row_reg == ROW_W'(ROW_DEPTH - 1));

    // load: latch request, form the starting bit offset
    assign width_next = eff_width(bpe_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            act_reg     <= req_action;
            width_reg   <= width_next;
            value_reg   <= req_write_value & low_ones(width_next);
            start_reg   <= START_W'(req_position) * START_W'(width_next);
            pos_bad_reg <= ({1'b0, req_position} >= count_reg);
        end
    end

    // lookup: word indexes, bank rows, range check
    assign last_bit   = start_reg + START_W'(width_reg) - START_W'(1);
    assign w0         = start_reg[START_W-1:OFFSET_W];
    assign w1         = last_bit[START_W-1:OFFSET_W];
    assign row0       = ROW_W'(32'(w0) >> 1);
    assign even_row   = row0 + ROW_W'(w0[0]);
    assign shift_wide = (SHIFT_W+1)'(PAIR_BITS)
                        - (SHIFT_W+1)'(start_reg[OFFSET_W-1:0])
                        - (SHIFT_W+1)'(width_reg);
    assign bad_next   = pos_bad_reg || (32'(w1) >= 32'(WORD_COUNT));

    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            straddle_reg <= (w0 != w1);
            bad_reg      <= bad_next;
            swap_reg     <= w0[0];
            shift_reg    <= shift_wide[SHIFT_W-1:0];
            even_row_reg <= even_row;
            odd_row_reg  <= row0;
        end
    end

    pbfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (ROW_DEPTH)
    ) u_even_bank (
        .clk   (clk),
        .we    (even_we),
        .waddr (even_waddr),
        .wdata (even_wdata),
        .re    (cmd.lookup),
        .raddr (even_row),
        .rdata (even_rdata)
    );

    pbfa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (ROW_DEPTH)
    ) u_odd_bank (
        .clk   (clk),
        .we    (odd_we),
        .waddr (odd_waddr),
        .wdata (odd_wdata),
        .re    (cmd.lookup),
        .raddr (row0),
        .rdata (odd_rdata)
    );

    // commit: first word on top, element sits shift_reg bits above the bottom
    assign pair       = swap_reg ? {odd_rdata, even_rdata} : {even_rdata, odd_rdata};
    assign field_mask = {{WORD_BITS{1'b0}}, low_ones(width_reg)} << shift_reg;
    assign field_ins  = {{WORD_BITS{1'b0}}, value_reg} << shift_reg;
    assign new_pair   = (pair & ~field_mask) | field_ins;
    assign extracted  = WORD_BITS'(pair >> shift_reg) & low_ones(width_reg);

    assign do_write   = cmd.commit && act_reg && !bad_reg;
    assign even_we    = cmd.clear || (do_write && (!swap_reg || straddle_reg));
    assign odd_we     = cmd.clear || (do_write && (swap_reg || straddle_reg));
    assign even_waddr = cmd.clear ? clr_row_reg : even_row_reg;
    assign odd_waddr  = cmd.clear ? clr_row_reg : odd_row_reg;
    assign even_wdata = cmd.clear ? '0 :
                        (swap_reg ? new_pair[WORD_BITS-1:0] : new_pair[PAIR_BITS-1:WORD_BITS]);
    assign odd_wdata  = cmd.clear ? '0 :
                        (swap_reg ? new_pair[PAIR_BITS-1:WORD_BITS] : new_pair[WORD_BITS-1:0]);

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            read_value_reg <= (bad_reg || act_reg) ? '0 : extracted;
            oor_reg        <= bad_reg;
        end
    end

    assign rsp_read_value   = read_value_reg;
    assign rsp_out_of_range = oor_reg;

endmodule

/* rtl/packed_bit_field_array_top.sv */
// top level of the packed bit field array: sequencer plus datapath
// sequence: the load step latches the request, the lookup step reads both banks into their
//   read registers, then the commit step loads the response register once the port is free
// intake: when idle or at the prior commit (lookup read, then commit write of the two banks)
// reset: async active low; afterwards a clearing pass zeroes all 512 rows of both banks, one
//   row per cycle, with request ready low; config writes are taken throughout
module packed_bit_field_array_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic [pbfa_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pbfa_pkg::CFG_DATA_W-1:0]  cfg_data,
    pbfa_req_if.sink                         req,
    pbfa_rsp_if.source                       rsp
);
    import pbfa_pkg::*;

    // command and status between sequencer and datapath
    pbfa_cmd_t    cmd;
    pbfa_status_t status;

    // sequencer: owns the state and the response valid flag
    pbfa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // datapath: config registers, word banks (even and odd words apart so a
    // straddling element reads both words at once and writes both at once), response payload
    pbfa_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .cmd              (cmd),
        .status           (status),
        .req_action       (req.action),
        .req_position     (req.position),
        .req_write_value  (req.write_value),
        .rsp_read_value   (rsp.read_value),
        .rsp_out_of_range (rsp.out_of_range)
    );

endmodule

/* rtl/pbfa_checker.sv */
// port level checks of the packed bit field array and their binding to the top level
module pbfa_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           req_valid,
    input logic                           req_ready,
    input logic                           rsp_valid,
    input logic                           rsp_ready,
    input logic [pbfa_pkg::WORD_BITS-1:0] rsp_read_value,
    input logic                           rsp_out_of_range
);

    // response held until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped before it was taken");

    // one request in flight: no request taken right after another
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken while previous one in lookup");

    // a taken request is followed by the response valid flag set
    a_rsp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |-> ##3 rsp_valid)
        else $error("no response after a request");

    // rejected access returns zero
    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_out_of_range |-> rsp_read_value == '0)
        else $error("out of range response with nonzero value");

endmodule

bind packed_bit_field_array_top pbfa_checker u_pbfa_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .req_valid        (req.valid),
    .req_ready        (req.ready),
    .rsp_valid        (rsp.valid),
    .rsp_ready        (rsp.ready),
    .rsp_read_value   (rsp.read_value),
    .rsp_out_of_range (rsp.out_of_range)
);

/* tb/tb_packed_bit_field_array_top.sv */
// self-checking testbench of the packed bit field array top level
module tb_packed_bit_field_array_top;
    import pbfa_pkg::*;

    // request action codes
    localparam logic ACT_READ  = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    localparam int RSP_LATENCY = 3;
    // cycles without any handshake before the run is declared hung; covers the
    // clearing pass after reset with plenty of margin
    localparam int STALL_LIMIT = 4000;
    localparam int REPORT_MAX  = 10;
    localparam int PHASE_ITEMS = 75;

    typedef struct packed {
        logic [WORD_BITS-1:0] read_value;
        logic                 out_of_range;
    } elem_rsp_t;

    // shadow copy of the packed store plus the queue of responses it owes
    class packed_array_model;
        logic [WORD_BITS-1:0] words [WORD_COUNT];
        logic [WIDTH_W-1:0]   width_cfg;
        logic [COUNT_W-1:0]   count_cfg;
        elem_rsp_t            owed_rsp [$];
        int                   mismatches;

        function new();
            foreach (words[i])
                words[i] = '0;
            width_cfg  = BITS_PER_ELEMENT_RST;
            count_cfg  = ELEMENT_COUNT_RST;
            mismatches = 0;
        endfunction

        function void set_config(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_BITS_PER_ELEMENT)
                width_cfg = data[WIDTH_W-1:0];
            else
                count_cfg = data[COUNT_W-1:0];
        endfunction

        // width zero behaves as one, anything past a word as a full word
        function int unsigned element_width();
            if (width_cfg == 0)
                return 1;
            if (width_cfg > WORD_BITS)
                return WORD_BITS;
            return width_cfg;
        endfunction

        // walk the element bit by bit, msb first from its start offset
        function void record_request(logic act, logic [POS_W-1:0] pos,
                                     logic [WORD_BITS-1:0] val);
            int unsigned b;
            int unsigned start;
            int unsigned at;
            elem_rsp_t   rsp;
            b = element_width();
            start = pos * b;
            rsp.read_value   = '0;
            rsp.out_of_range = 1'b0;
            if (pos >= count_cfg || (start + b - 1) / WORD_BITS >= WORD_COUNT)
                rsp.out_of_range = 1'b1;
            else
                for (int unsigned i = 0; i < b; i++) begin
                    at = start + i;
                    if (act == ACT_WRITE)
                        words[at / WORD_BITS][WORD_BITS - 1 - at % WORD_BITS] = val[b - 1 - i];
                    else
                        rsp.read_value[b - 1 - i] =
                            words[at / WORD_BITS][WORD_BITS - 1 - at % WORD_BITS];
                end
            owed_rsp.push_back(rsp);
        endfunction

        function void flag(string msg);
            if (mismatches < REPORT_MAX)
                $display("mismatch at %0t: %s", $realtime, msg);
            mismatches++;
        endfunction

        function void check_response(logic [WORD_BITS-1:0] rv, logic oor);
            elem_rsp_t want;
            if (owed_rsp.size() == 0) begin
                flag($sformatf("response with nothing outstanding: value %h range flag %b",
                               rv, oor));
                return;
            end
            want = owed_rsp.pop_front();
            if (rv !== want.read_value)
                flag($sformatf("read_value expected %h actual %h", want.read_value, rv));
            if (oor !== want.out_of_range)
                flag($sformatf("out_of_range expected %b actual %b", want.out_of_range, oor));
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    pbfa_req_if req_ch ();
    pbfa_rsp_if rsp_ch ();

    packed_array_model shadow;

    // idling percentages of the current phase
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int stalled_cycles = 0;

    // per phase setting of the random part; extremes and the clamped widths included
    int unsigned phase_width [8] = '{1, 64, 13, 33, 0, 127, 63, 7};
    int unsigned phase_count [8] = '{65536, 65536, 5000, 2000, 300, 1024, 65535, 9000};
    // idling modes: none, sender only, receiver only, both
    int          mode_idle   [4] = '{0, 56, 0, 33};
    int          mode_stall  [4] = '{0, 0, 56, 33};

    always #1 clk = ~clk;

    packed_bit_field_array_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .req       (req_ch),
        .rsp       (rsp_ch)
    );

    // receiver side: ready changes on the falling edge only
    always @(negedge clk)
        if (rst_n)
            rsp_ch.ready = ($urandom_range(99, 0) >= recv_stall_pct);

    // handshakes are sampled at the rising edge, before the block updates;
    // the same edge feeds the watchdog
    always @(posedge clk) begin
        if (req_ch.valid && req_ch.ready)
            shadow.record_request(req_ch.action, req_ch.position, req_ch.write_value);
        if (rsp_ch.valid && rsp_ch.ready)
            shadow.check_response(rsp_ch.read_value, rsp_ch.out_of_range);
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stalled_cycles = 0;
        else begin
            stalled_cycles++;
            if (stalled_cycles >= STALL_LIMIT) begin
                $display("** packed_bit_field_array_top: FAILED **");
                $finish;
            end
        end
    end

    // register write, entered and left at a falling edge
    task automatic write_config(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
        shadow.set_config(idx, data);
    endtask

    // one request; random idle cycles first, then hold until accepted
    task automatic send_request(input logic act, input logic [POS_W-1:0] pos,
                                input logic [WORD_BITS-1:0] val);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge clk);
        end
        req_ch.valid       = 1'b1;
        req_ch.action      = act;
        req_ch.position    = pos;
        req_ch.write_value = val;
        do
            @(posedge clk);
        while (!req_ch.ready);
        @(negedge clk);
    endtask

    // stop sending and wait for every owed response
    task automatic drain_responses();
        req_ch.valid = 1'b0;
        while (shadow.owed_rsp.size() != 0)
            @(negedge clk);
    endtask

    // positions: most often a small hot window so reads see earlier writes, then the
    // whole legal span, the count or memory boundary, and any 16-bit value
    function automatic logic [POS_W-1:0] pick_position();
        int lim;
        int roll;
        int p;
        lim = (WORD_COUNT * WORD_BITS) / shadow.element_width();
        if (shadow.count_cfg < lim)
            lim = shadow.count_cfg;
        roll = $urandom_range(99, 0);
        if (lim == 0 || roll >= 85)
            p = $urandom_range(65535, 0);
        else if (roll < 40)
            p = $urandom_range(((lim < 64) ? lim : 64) - 1, 0);
        else if (roll < 70)
            p = $urandom_range(lim - 1, 0);
        else
            p = lim - 3 + int'($urandom_range(5, 0));
        if (p < 0)
            p = 0;
        if (p > 65535)
            p = 65535;
        return POS_W'(p);
    endfunction

    function automatic logic [WORD_BITS-1:0] pick_value();
        int roll;
        roll = $urandom_range(9, 0);
        if (roll == 0)
            return '1;
        if (roll == 1)
            return WORD_BITS'($urandom_range(3, 0));
        return {$urandom, $urandom};
    endfunction

    initial begin
        shadow = new();
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_BITS_PER_ELEMENT;
        cfg_data           = '0;
        req_ch.valid       = 1'b0;
        req_ch.action      = ACT_READ;
        req_ch.position    = '0;
        req_ch.write_value = '0;
        rsp_ch.ready       = 1'b0;
        repeat (8) @(negedge clk);
        rst_n = 1'b1;

        // reset setting: 8-bit elements, 8192 in use
        send_request(ACT_READ,  16'd0,     '0);                    // cleared store reads zero
        send_request(ACT_WRITE, 16'd0,     '1);                    // high bits dropped
        send_request(ACT_READ,  16'd0,     '0);
        send_request(ACT_READ,  16'd1,     '0);                    // neighbor untouched
        send_request(ACT_WRITE, 16'd8191,  64'hFFFF_FFFF_FFFF_FFA5);
        send_request(ACT_READ,  16'd8191,  '0);                    // last element of the count
        send_request(ACT_READ,  16'd8192,  '0);                    // position past count
        send_request(ACT_WRITE, 16'd65535, '1);                    // rejected write
        drain_responses();

        // width zero behaves as one bit, every position in use
        write_config(CFG_BITS_PER_ELEMENT, '0);
        write_config(CFG_ELEMENT_COUNT, 17'd65536);
        send_request(ACT_WRITE, 16'd65535, 64'h3);                 // very last bit of memory
        send_request(ACT_READ,  16'd65535, '0);
        send_request(ACT_READ,  16'd65534, '0);
        send_request(ACT_WRITE, 16'd0,     '0);
        send_request(ACT_READ,  16'd1,     '0);                    // old byte reinterpreted
        drain_responses();

        // width above a word clamps to 64
        write_config(CFG_BITS_PER_ELEMENT, 17'd127);
        send_request(ACT_READ,  16'd0,     '0);
        send_request(ACT_WRITE, 16'd1023,  64'hDEAD_BEEF_0123_4567);
        send_request(ACT_READ,  16'd1023,  '0);
        send_request(ACT_READ,  16'd1024,  '0);                    // past the memory end
        drain_responses();

        // 13-bit elements straddle word boundaries
        write_config(CFG_BITS_PER_ELEMENT, 17'd13);
        write_config(CFG_ELEMENT_COUNT, 17'd100);
        send_request(ACT_WRITE, 16'd4,     '1);                    // bits 52..64, two words
        send_request(ACT_READ,  16'd4,     '0);
        send_request(ACT_READ,  16'd3,     '0);
        send_request(ACT_WRITE, 16'd99,    64'h1234_5678);
        send_request(ACT_READ,  16'd99,    '0);
        send_request(ACT_READ,  16'd100,   '0);                    // past count
        drain_responses();

        // empty array: everything rejected
        write_config(CFG_ELEMENT_COUNT, '0);
        send_request(ACT_READ,  16'd0,     '0);
        drain_responses();

        // random part, one setting and one idling mode per phase
        for (int ph = 0; ph < 8; ph++) begin
            write_config(CFG_BITS_PER_ELEMENT, CFG_DATA_W'(phase_width[ph]));
            write_config(CFG_ELEMENT_COUNT, CFG_DATA_W'(phase_count[ph]));
            send_idle_pct  = mode_idle[ph % 4];
            recv_stall_pct = mode_stall[ph % 4];
            repeat (PHASE_ITEMS)
                send_request(($urandom_range(1, 0) == 1) ? ACT_WRITE : ACT_READ,
                             pick_position(), pick_value());
            drain_responses();
        end

        // let any stray response show up before judging
        repeat (2 * RSP_LATENCY + 2) @(negedge clk);
        if (shadow.mismatches == 0)
            $display("** packed_bit_field_array_top: PASSED **");
        else
            $display("** packed_bit_field_array_top: FAILED **");
        $finish;
    end

endmodule

/* packed_bit_field_array_top.f */
rtl/pbfa_pkg.sv
rtl/pbfa_if.sv
rtl/pbfa_ram.sv
rtl/pbfa_ctrl.sv
rtl/pbfa_dp.sv
rtl/packed_bit_field_array_top.sv
rtl/pbfa_checker.sv
tb/tb_packed_bit_field_array_top.sv
